// File: src/lcim_pkg.sv
// ----------------------------------------------------------------------------
// lcim_pkg
// Types and constants shared by the legend color index mapper.
// ----------------------------------------------------------------------------
package lcim_pkg;

  localparam int MAX_INTERVALS_DEF = 16;
  localparam int COORD_BITS_DEF    = 12;
  localparam int QUEUE_DEPTH       = 2;
  localparam int VAL_W             = 38;
  localparam int LOG10_OF_2_Q16    = 19728;
  localparam logic [7:0] TOP_INDEX = 8'd239;

  typedef enum logic [0:0] {
    OP_MAP   = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    CFG_CONTROL   = 3'd0,
    CFG_NODATA    = 3'd1,
    CFG_RANGE_LO  = 3'd2,
    CFG_RANGE_HI  = 3'd3,
    CFG_STEP      = 3'd4,
    CFG_SCALE     = 3'd5,
    CFG_OFFSET    = 3'd6,
    CFG_LOG_RECIP = 3'd7
  } cfg_addr_t;

  typedef enum logic [1:0] {
    KIND_WRITE    = 2'd0,
    KIND_INTERVAL = 2'd1,
    KIND_LINEAR   = 2'd2
  } kind_t;

  typedef struct packed {
    logic               operation;
    logic [11:0]        pixel_x;
    logic [11:0]        pixel_y;
    logic signed [31:0] sample_value;
    logic               sample_is_nan;
    logic [3:0]         entry_index;
    logic signed [31:0] entry_min;
    logic signed [31:0] entry_max;
    logic [31:0]        entry_color;
  } in_item_t;

  typedef struct packed {
    logic [11:0] out_x;
    logic [11:0] out_y;
    logic        is_indexed;
    logic [7:0]  color_index;
    logic [31:0] direct_color;
  } out_item_t;

  typedef struct packed {
    logic [63:0]        control;
    logic signed [31:0] nodata_value;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [30:0]        shade_step;
    logic signed [31:0] legend_scale;
    logic signed [31:0] legend_offset;
    logic signed [31:0] log_divisor_recip;
  } cfg_t;

  typedef struct packed {
    kind_t    kind;
    in_item_t item;
  } qent_t;

endpackage

// File: src/legend_color_index_mapper_unit.sv
// ----------------------------------------------------------------------------
// legend_color_index_mapper_unit
// Maps a Q16.16 sample at a pixel to a palette index or a direct color.
// ----------------------------------------------------------------------------
// channel  handshake           payload
// in       in_valid/in_stall   in_data (in_item_t)
// out      out_valid/out_stall out_data (out_item_t)
// cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// dropped samples never enter the queue; table writes are stored when popped;
// interval search reads and compares each entry in turn; linear mapping runs
// an optional log10 normalize and squaring, the quantization divider when
// shade_step is nonzero, then scale and offset. synchronous reset clears
// control; the table is unset. out_stall holds the output register; the back
// end fills a one-deep result slot and the queue keeps the front accepting.
module legend_color_index_mapper_unit #(
  parameter int MAX_INTERVALS = lcim_pkg::MAX_INTERVALS_DEF,
  parameter int COORD_BITS    = lcim_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcim_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lcim_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import lcim_pkg::*;

  cfg_t  cfg;
  logic  q_full;
  logic  push;
  qent_t push_data;
  logic  pop;
  logic  q_valid;
  qent_t q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{control: '0, nodata_value: '0, range_low: '0, range_high: '0,
               shade_step: '0, legend_scale: 32'sd65536, legend_offset: '0,
               log_divisor_recip: 32'sd65536};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr_t'(cfg_index))
        CFG_CONTROL:   cfg.control           <= cfg_data;
        CFG_NODATA:    cfg.nodata_value      <= cfg_data[31:0];
        CFG_RANGE_LO:  cfg.range_low         <= cfg_data[31:0];
        CFG_RANGE_HI:  cfg.range_high        <= cfg_data[31:0];
        CFG_STEP:      cfg.shade_step        <= cfg_data[30:0];
        CFG_SCALE:     cfg.legend_scale      <= cfg_data[31:0];
        CFG_OFFSET:    cfg.legend_offset     <= cfg_data[31:0];
        CFG_LOG_RECIP: cfg.log_divisor_recip <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  lcim_front #(.COORD_BITS(COORD_BITS)) u_front (
    .cfg(cfg), .in_valid(in_valid), .in_data(in_data), .q_full(q_full),
    .in_stall(in_stall), .push(push), .push_data(push_data)
  );

  lcim_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(q_full),
    .pop(pop), .q_valid(q_valid), .q_data(q_data)
  );

  lcim_back #(.MAX_INTERVALS(MAX_INTERVALS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_data(q_data),
    .pop(pop), .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
  );

endmodule

// File: src/lcim_front.sv
// ----------------------------------------------------------------------------
// lcim_front
// Accepts items, drops rejected samples and tags the rest for the back end.
// ----------------------------------------------------------------------------
module lcim_front #(
  parameter int COORD_BITS = lcim_pkg::COORD_BITS_DEF
) (
  input  lcim_pkg::cfg_t     cfg,
  input  logic               in_valid,
  input  lcim_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               in_stall,
  output logic               push,
  output lcim_pkg::qent_t    push_data
);
  import lcim_pkg::*;

  localparam logic [11:0] CMASK = (COORD_BITS >= 12) ? 12'hfff :
                                  12'((1 << COORD_BITS) - 1);

  logic drop;

  always_comb begin
    drop = 1'b0;
    if (in_data.operation == OP_MAP) begin
      if (in_data.sample_is_nan) drop = 1'b1;
      if (cfg.control[0] && in_data.sample_value == cfg.nodata_value) drop = 1'b1;
      if (cfg.control[1] && (in_data.sample_value < cfg.range_low ||
                             in_data.sample_value > cfg.range_high)) drop = 1'b1;
    end
  end

  always_comb begin
    push_data = '{kind: KIND_WRITE, item: in_data};
    push_data.item.pixel_x = in_data.pixel_x & CMASK;
    push_data.item.pixel_y = in_data.pixel_y & CMASK;
    if (in_data.operation == OP_WRITE) begin
      push_data.kind = KIND_WRITE;
    end else if (cfg.control[2] && cfg.shade_step == '0) begin
      push_data.kind = KIND_INTERVAL;
    end else begin
      push_data.kind = KIND_LINEAR;
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full && !drop;

endmodule

// File: src/lcim_queue.sv
// ----------------------------------------------------------------------------
// lcim_queue
// Short queue between the front and back ends.
// ----------------------------------------------------------------------------
module lcim_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lcim_pkg::qent_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output lcim_pkg::qent_t q_data
);
  import lcim_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  qent_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: src/lcim_back.sv
// ----------------------------------------------------------------------------
// lcim_back
// Interval search, log10, quantization and index arithmetic, one item at a time.
// ----------------------------------------------------------------------------
module lcim_back #(
  parameter int MAX_INTERVALS = lcim_pkg::MAX_INTERVALS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  lcim_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  lcim_pkg::qent_t     q_data,
  output logic                pop,
  output logic                out_valid,
  output lcim_pkg::out_item_t out_data,
  input  logic                out_stall
);
  import lcim_pkg::*;

  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam logic signed [VAL_W-1:0] VMAX = VAL_W'(64'sd2147483647);
  localparam logic signed [VAL_W-1:0] VMIN = ~VMAX;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_RD   = 13'b0000000000010,
    S_CMP  = 13'b0000000000100,
    S_BG   = 13'b0000000001000,
    S_NORM = 13'b0000000010000,
    S_SQ   = 13'b0000000100000,
    S_L10  = 13'b0000001000000,
    S_LOG  = 13'b0000010000000,
    S_QSET = 13'b0000100000000,
    S_DIV  = 13'b0001000000000,
    S_QFIX = 13'b0010000000000,
    S_MUL  = 13'b0100000000000,
    S_SUM  = 13'b1000000000000
  } state_t;

  state_t                    state;
  qent_t                     cur;
  logic [95:0]               mem [MAX_INTERVALS];
  logic [95:0]               mem_q;
  logic [CW-1:0]             j;
  logic [CW-1:0]             cnt_eff;
  logic signed [VAL_W-1:0]   val;
  logic [31:0]               nm;
  logic [4:0]                p;
  logic [15:0]               frac;
  logic [3:0]                it;
  logic signed [20:0]        l10;
  logic [VAL_W-1:0]          mag;
  logic                      neg;
  logic [30:0]               rem;
  logic [5:0]                bitc;
  logic signed [63:0]        prod;
  logic                      res_pend;
  out_item_t                 res;

  logic [63:0]               sq;
  logic signed [20:0]        l2;
  logic signed [41:0]        l10_prod;
  logic signed [53:0]        lg_prod;
  logic [31:0]               rem2;
  logic [31:0]               rem_diff;
  logic signed [VAL_W-1:0]   stepv;
  logic signed [VAL_W-1:0]   remv;
  logic signed [VAL_W-1:0]   vc;
  logic signed [63:0]        sum;
  logic                      out_free;
  logic                      hit;

  assign cnt_eff  = (cfg.control[12:8] > 5'(MAX_INTERVALS)) && (MAX_INTERVALS < 32) ?
                    CW'(MAX_INTERVALS) : CW'(cfg.control[12:8]);
  assign sq       = nm * nm;
  assign l2       = signed'({~p[4], p[3:0], frac});
  assign l10_prod = 42'(l2) * 42'sd19728;
  assign lg_prod  = 54'(l10) * 54'(cfg.log_divisor_recip);
  assign rem2     = {rem, mag[VAL_W-1]};
  assign rem_diff = rem2 - {1'b0, cfg.shade_step};
  assign stepv    = signed'(VAL_W'({1'b0, cfg.shade_step}));
  assign remv     = signed'(VAL_W'({1'b0, rem}));
  assign vc       = (val > VMAX) ? VMAX : (val < VMIN) ? VMIN : val;
  assign sum      = prod + (64'(cfg.legend_offset) <<< 16);
  assign out_free = !out_valid || !out_stall;
  assign hit      = $signed(cur.item.sample_value) >= $signed(mem_q[95:64]) &&
                    $signed(cur.item.sample_value) <  $signed(mem_q[63:32]);
  assign pop      = (state == S_IDLE) && !res_pend && q_valid;

  // interval store
  always_ff @(posedge clk) begin
    if (pop && q_data.kind == KIND_WRITE &&
        32'(q_data.item.entry_index) < 32'(MAX_INTERVALS)) begin
      mem[AW'(q_data.item.entry_index)] <= {q_data.item.entry_min,
                                            q_data.item.entry_max,
                                            q_data.item.entry_color};
    end
    if (state == S_RD) mem_q <= mem[j[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= res_pend;
        if (res_pend) begin
          out_data <= res;
          res_pend <= 1'b0;
        end
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            cur <= q_data;
            j   <= '0;
            res.out_x        <= q_data.item.pixel_x;
            res.out_y        <= q_data.item.pixel_y;
            res.is_indexed   <= 1'b0;
            res.color_index  <= '0;
            res.direct_color <= '0;
            case (q_data.kind)
              KIND_INTERVAL: state <= (cnt_eff == '0) ? S_BG : S_RD;
              KIND_LINEAR: begin
                if (cfg.control[3] && q_data.item.sample_value > 0) begin
                  nm    <= q_data.item.sample_value;
                  p     <= 5'd31;
                  state <= S_NORM;
                end else begin
                  val   <= cfg.control[3] ? -VAL_W'(cfg.legend_offset) :
                                            VAL_W'(q_data.item.sample_value);
                  state <= S_QSET;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (hit) begin
            res.direct_color <= mem_q[31:0];
            res_pend <= 1'b1;
            state    <= S_IDLE;
          end else if (j + 1'b1 == cnt_eff) begin
            state <= S_BG;
          end else begin
            j     <= j + 1'b1;
            state <= S_RD;
          end
        end
        S_BG: begin
          if (cfg.control[4]) begin
            res.direct_color <= cfg.control[63:32];
            res_pend <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_NORM: begin
          if (nm[31]) begin
            it    <= '0;
            frac  <= '0;
            state <= S_SQ;
          end else begin
            nm <= nm << 1;
            p  <= p - 1'b1;
          end
        end
        S_SQ: begin
          if (sq[63]) begin
            nm   <= sq[63:32];
            frac <= {frac[14:0], 1'b1};
          end else begin
            nm   <= sq[62:31];
            frac <= {frac[14:0], 1'b0};
          end
          it <= it + 1'b1;
          if (it == 4'd15) state <= S_L10;
        end
        S_L10: begin
          l10   <= l10_prod[36:16];
          state <= S_LOG;
        end
        S_LOG: begin
          val   <= lg_prod[16+VAL_W-1:16];
          state <= S_QSET;
        end
        S_QSET: begin
          neg  <= val < 0;
          mag  <= (val < 0) ? unsigned'(-val) : unsigned'(val);
          rem  <= '0;
          bitc <= 6'(VAL_W);
          state <= (cfg.shade_step == '0) ? S_MUL : S_DIV;
        end
        S_DIV: begin
          rem  <= rem_diff[31] ? rem2[30:0] : rem_diff[30:0];
          mag  <= mag << 1;
          bitc <= bitc - 1'b1;
          if (bitc == 6'd1) state <= S_QFIX;
        end
        S_QFIX: begin
          if (!neg) val <= val - remv;
          else if (rem != '0) val <= val - (stepv - remv);
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= 32'(vc) * cfg.legend_scale;
          state <= S_SUM;
        end
        S_SUM: begin
          res.is_indexed <= 1'b1;
          if (sum < 0) res.color_index <= '0;
          else if (sum[63:32] > 32'(TOP_INDEX)) res.color_index <= TOP_INDEX;
          else res.color_index <= sum[39:32];
          res_pend <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/lcim_checker.sv
// ----------------------------------------------------------------------------
// lcim_port_checker
// Port-level checks on the legend color index mapper.
// ----------------------------------------------------------------------------
module lcim_port_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input lcim_pkg::out_item_t out_data
);
  import lcim_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled beat changed");

  a_index_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_indexed |->
      out_data.direct_color == '0 && out_data.color_index <= TOP_INDEX)
    else $error("bad palette beat");

  a_direct_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_indexed |-> out_data.color_index == '0)
    else $error("bad direct color beat");

endmodule

bind legend_color_index_mapper_unit lcim_port_checker u_lcim_port_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);
